[rtl/core/efm_pkg.sv]
// Shared types and constants for the elliptic fade mask pixel unit.
package efm_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned COEF_W  = 24;
    localparam int unsigned SCALE_W = 20;
    localparam int unsigned POS_W   = 22;
    localparam int unsigned TRIG_W  = 16;
    localparam int unsigned COL_W   = 12;
    localparam int unsigned FADE_W  = 17;
    localparam int unsigned DIFF_W  = 24;   // centre offset, Q.8
    localparam int unsigned SCL_W   = 29;   // scaled offset, Q.8
    localparam int unsigned ROT_W   = 31;   // rotated offset, Q.8
    localparam int unsigned NORM_W  = 32;   // squared norm, Q.16
    localparam int unsigned QUO_W   = 17;

    localparam logic [NORM_W-1:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [FADE_W-1:0] FADE_ONE = 17'h1_0000;

    typedef enum logic [2:0] {
        REG_SHAPE_X = 3'd0,
        REG_SHAPE_Y = 3'd1,
        REG_FADE_X  = 3'd2,
        REG_FADE_Y  = 3'd3,
        REG_ISCL_X  = 3'd4,
        REG_ISCL_Y  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        RK_ZERO,
        RK_ONE,
        RK_DIV
    } t_res_kind;

    typedef struct packed {
        logic [COEF_W-1:0] shape_x;
        logic [COEF_W-1:0] shape_y;
        logic [COEF_W-1:0] fade_x;
        logic [COEF_W-1:0] fade_y;
    } t_coefs;

endpackage

[rtl/core/efm_xform.sv]
// Offset, inverse scale and rotation stages (three registered stages).
module efm_xform
    import efm_pkg::*;
#(
    parameter int unsigned MAX_ROW_WIDTH = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [COL_W-1:0]          i_column,
    input  logic signed [POS_W-1:0]   i_row_position,
    input  logic signed [POS_W-1:0]   i_centre_x,
    input  logic signed [POS_W-1:0]   i_centre_y,
    input  logic signed [TRIG_W-1:0]  i_cos_angle,
    input  logic signed [TRIG_W-1:0]  i_sin_angle,
    input  logic [SCALE_W-1:0]        i_iscl_x,
    input  logic [SCALE_W-1:0]        i_iscl_y,
    output logic                      o_vld,
    output logic signed [ROT_W-1:0]   o_xr,
    output logic signed [ROT_W-1:0]   o_yr
);

    localparam logic [16:0] ROW_LIM = 17'(MAX_ROW_WIDTH);
    localparam logic [16:0] ROW_TOP = 17'(MAX_ROW_WIDTH - 1);

    logic [2:0]               r_vld;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic signed [TRIG_W-1:0] r_cos1, r_sin1, r_cos2, r_sin2;
    logic signed [SCL_W-1:0]  r_xs, r_ys;
    logic signed [ROT_W-1:0]  r_xr, r_yr;

    logic [COL_W-1:0]         col_sat;
    logic signed [DIFF_W-1:0] n_dx, n_dy;
    logic signed [44:0]       px, py;
    logic signed [44:0]       pxc, pys, pxs, pyc;
    logic signed [45:0]       sum_x, sum_y;

    always_comb begin
        col_sat = i_column;
        if ({5'b0, i_column} >= ROW_LIM) begin
            col_sat = ROW_TOP[COL_W-1:0];
        end
        n_dx = $signed({4'b0, col_sat, 8'b0}) - DIFF_W'(i_centre_x);
        n_dy = DIFF_W'(i_row_position) - DIFF_W'(i_centre_y);
        px   = $signed(r_dx) * $signed({1'b0, i_iscl_x});
        py   = $signed(r_dy) * $signed({1'b0, i_iscl_y});
        pxc  = r_xs * r_cos2;
        pys  = r_ys * r_sin2;
        pxs  = r_xs * r_sin2;
        pyc  = r_ys * r_cos2;
        sum_x = 46'(pxc) - 46'(pys);
        sum_y = 46'(pxs) + 46'(pyc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_cos1 <= i_cos_angle;
        r_sin1 <= i_sin_angle;
        r_xs   <= px[44:16];
        r_ys   <= py[44:16];
        r_cos2 <= r_cos1;
        r_sin2 <= r_sin1;
        r_xr   <= sum_x[45:15];
        r_yr   <= sum_y[45:15];
    end

    assign o_vld = r_vld[2];
    assign o_xr  = r_xr;
    assign o_yr  = r_yr;

endmodule

[rtl/core/efm_norm.sv]
// Weighted squared norms of the rotated offset (three registered stages).
module efm_norm
    import efm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic signed [ROT_W-1:0]  i_xr,
    input  logic signed [ROT_W-1:0]  i_yr,
    input  t_coefs                   i_coefs,
    output logic                     o_vld,
    output logic [NORM_W-1:0]        o_n,
    output logic [NORM_W-1:0]        o_f
);

    logic [2:0]          r_vld;
    logic signed [39:0]  r_tsx, r_tsy, r_tfx, r_tfy;
    logic [32:0]         r_qsx, r_qsy, r_qfx, r_qfy;
    logic [NORM_W-1:0]   r_n, r_f;

    logic signed [55:0]  p_sx, p_sy, p_fx, p_fy;
    logic [33:0]         sum_n, sum_f;

    // Square of the term magnitude, pinned at 2^32 once the magnitude leaves 16 bits.
    function automatic logic [32:0] sq_sat(input logic signed [39:0] t);
        logic [39:0] a;
        logic [15:0] m;
        a = t[39] ? 40'(-t) : 40'(t);
        m = a[15:0];
        if (a[39:16] != '0) begin
            sq_sat = 33'h1_0000_0000;
        end else begin
            sq_sat = {1'b0, 32'(m) * 32'(m)};
        end
    endfunction

    always_comb begin
        p_sx  = i_xr * $signed({1'b0, i_coefs.shape_x});
        p_sy  = i_yr * $signed({1'b0, i_coefs.shape_y});
        p_fx  = i_xr * $signed({1'b0, i_coefs.fade_x});
        p_fy  = i_yr * $signed({1'b0, i_coefs.fade_y});
        sum_n = 34'(r_qsx) + 34'(r_qsy);
        sum_f = 34'(r_qfx) + 34'(r_qfy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tsx <= p_sx[55:16];
        r_tsy <= p_sy[55:16];
        r_tfx <= p_fx[55:16];
        r_tfy <= p_fy[55:16];
        r_qsx <= sq_sat(r_tsx);
        r_qsy <= sq_sat(r_tsy);
        r_qfx <= sq_sat(r_tfx);
        r_qfy <= sq_sat(r_tfy);
        r_n   <= (sum_n[33:32] != 2'b0) ? '1 : sum_n[31:0];
        r_f   <= (sum_f[33:32] != 2'b0) ? '1 : sum_f[31:0];
    end

    assign o_vld = r_vld[2];
    assign o_n   = r_n;
    assign o_f   = r_f;

endmodule

[rtl/core/efm_div.sv]
// Case split, numerator product and a pipelined restoring divider, one quotient bit a stage.
module efm_div
    import efm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [NORM_W-1:0]   i_n,
    input  logic [NORM_W-1:0]   i_f,
    output logic                o_vld,
    output logic [FADE_W-1:0]   o_fade_value
);

    localparam int unsigned NST = QUO_W;

    // front stages
    logic              r_vld_a, r_vld_b;
    logic [63:0]       r_num_a, r_num_b;
    logic [NORM_W-1:0] r_den_a, r_den_b;
    t_res_kind         r_kind_a, r_kind_b;

    // divider stages
    logic              r_vld_d  [0:NST];
    logic [63:0]       r_rem    [0:NST];
    logic [NORM_W-1:0] r_den    [0:NST];
    logic [QUO_W-1:0]  r_quo    [0:NST];
    t_res_kind         r_kind   [0:NST];

    logic              r_out_vld;
    logic [FADE_W-1:0] r_out;

    t_res_kind         n_kind_a, n_kind_b;
    logic [63:0]       n_num;
    logic [NORM_W-1:0] f_m1;

    always_comb begin
        f_m1  = i_f - ONE_Q16;
        n_num = i_n * f_m1;
        if (i_f < ONE_Q16) begin
            n_kind_a = RK_ZERO;
        end else if (i_f == i_n) begin
            n_kind_a = RK_ONE;
        end else if (i_f < i_n) begin
            n_kind_a = RK_ZERO;
        end else begin
            n_kind_a = RK_DIV;
        end
        n_kind_b = r_kind_a;
        // quotient of 2^17 or more clamps anyway
        if (r_kind_a == RK_DIV && r_num_a >= {15'b0, r_den_a, 17'b0}) begin
            n_kind_b = RK_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a   <= 1'b0;
            r_vld_b   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i <= NST; i++) begin
                r_vld_d[i] <= 1'b0;
            end
        end else begin
            r_vld_a    <= i_vld;
            r_vld_b    <= r_vld_a;
            r_vld_d[0] <= r_vld_b;
            for (int i = 1; i <= NST; i++) begin
                r_vld_d[i] <= r_vld_d[i-1];
            end
            r_out_vld  <= r_vld_d[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        r_num_a  <= n_num;
        r_den_a  <= i_f - i_n;
        r_kind_a <= n_kind_a;
        r_num_b  <= r_num_a;
        r_den_b  <= r_den_a;
        r_kind_b <= n_kind_b;
        r_rem[0]  <= r_num_b;
        r_den[0]  <= r_den_b;
        r_quo[0]  <= '0;
        r_kind[0] <= r_kind_b;
        for (int i = 1; i <= NST; i++) begin
            r_den[i]  <= r_den[i-1];
            r_kind[i] <= r_kind[i-1];
            if (r_rem[i-1] >= (64'(r_den[i-1]) << (NST - i))) begin
                r_rem[i] <= r_rem[i-1] - (64'(r_den[i-1]) << (NST - i));
                r_quo[i] <= r_quo[i-1] | (QUO_W'(1) << (NST - i));
            end else begin
                r_rem[i] <= r_rem[i-1];
                r_quo[i] <= r_quo[i-1];
            end
        end
        unique case (r_kind[NST])
            RK_ZERO: r_out <= '0;
            RK_ONE:  r_out <= FADE_ONE;
            RK_DIV:  r_out <= (r_quo[NST] > FADE_ONE) ? FADE_ONE : r_quo[NST];
            default: r_out <= '0;
        endcase
    end

    assign o_vld        = r_out_vld;
    assign o_fade_value = r_out;

endmodule

[rtl/core/elliptic_fade_mask_pixel_unit.sv]
// Top level: register port, pixel pipeline and result strobe.
// One pixel is taken per clock whenever start is high; busy never rises. Each pixel's fade
// value appears for one cycle with o_done high after it passes 3 stages of offset, scale
// and rotation, 3 of weighted norms, 2 of case split and numerator product, 1 that loads
// the divider, 17 of the restoring divider (one quotient bit a stage) and 1 of clamp into
// the output register.
// Results cannot be held off, so the caller must take o_fade_value whenever o_done is high.
module elliptic_fade_mask_pixel_unit
    import efm_pkg::*;
#(
    parameter int unsigned MAX_ROW_WIDTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic [COL_W-1:0]         i_column,
    input  logic signed [POS_W-1:0]  i_row_position,
    input  logic signed [POS_W-1:0]  i_centre_x,
    input  logic signed [POS_W-1:0]  i_centre_y,
    input  logic signed [TRIG_W-1:0] i_cos_angle,
    input  logic signed [TRIG_W-1:0] i_sin_angle,
    output logic                     o_done,
    output logic [FADE_W-1:0]        o_fade_value
);

    t_coefs             r_coefs;
    logic [SCALE_W-1:0] r_iscl_x, r_iscl_y;

    t_reg_idx           reg_idx;
    logic               wr_en;
    logic               xf_vld, nm_vld;
    logic signed [ROT_W-1:0] xr, yr;
    logic [NORM_W-1:0]  nrm_n, nrm_f;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.shape_x <= 24'h01_0000;
            r_coefs.shape_y <= 24'h01_0000;
            r_coefs.fade_x  <= 24'h01_0000;
            r_coefs.fade_y  <= 24'h01_0000;
            r_iscl_x        <= 20'h1_0000;
            r_iscl_y        <= 20'h1_0000;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SHAPE_X: r_coefs.shape_x <= pwdata[COEF_W-1:0];
                REG_SHAPE_Y: r_coefs.shape_y <= pwdata[COEF_W-1:0];
                REG_FADE_X:  r_coefs.fade_x  <= pwdata[COEF_W-1:0];
                REG_FADE_Y:  r_coefs.fade_y  <= pwdata[COEF_W-1:0];
                REG_ISCL_X:  r_iscl_x        <= pwdata[SCALE_W-1:0];
                REG_ISCL_Y:  r_iscl_y        <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SHAPE_X: prdata = DATA_W'(r_coefs.shape_x);
            REG_SHAPE_Y: prdata = DATA_W'(r_coefs.shape_y);
            REG_FADE_X:  prdata = DATA_W'(r_coefs.fade_x);
            REG_FADE_Y:  prdata = DATA_W'(r_coefs.fade_y);
            REG_ISCL_X:  prdata = DATA_W'(r_iscl_x);
            REG_ISCL_Y:  prdata = DATA_W'(r_iscl_y);
            default:     prdata = '0;
        endcase
    end

    efm_xform #(
        .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
    ) u_xform (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (start),
        .i_column       (i_column),
        .i_row_position (i_row_position),
        .i_centre_x     (i_centre_x),
        .i_centre_y     (i_centre_y),
        .i_cos_angle    (i_cos_angle),
        .i_sin_angle    (i_sin_angle),
        .i_iscl_x       (r_iscl_x),
        .i_iscl_y       (r_iscl_y),
        .o_vld          (xf_vld),
        .o_xr           (xr),
        .o_yr           (yr)
    );

    efm_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (xf_vld),
        .i_xr    (xr),
        .i_yr    (yr),
        .i_coefs (r_coefs),
        .o_vld   (nm_vld),
        .o_n     (nrm_n),
        .o_f     (nrm_f)
    );

    efm_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (nm_vld),
        .i_n          (nrm_n),
        .i_f          (nrm_f),
        .o_vld        (o_done),
        .o_fade_value (o_fade_value)
    );

endmodule

[dv/elliptic_fade_mask_pixel_unit_test.sv]
// Testbench for the elliptic fade mask pixel unit: random and directed pixels, fade scoreboard.
module elliptic_fade_mask_pixel_unit_test;
    import efm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROW_MAX = 4096;
    localparam int unsigned LATENCY = 27;

    typedef struct {
        logic [COL_W-1:0]         column;
        logic signed [POS_W-1:0]  row_pos;
        logic signed [POS_W-1:0]  cx;
        logic signed [POS_W-1:0]  cy;
        logic signed [TRIG_W-1:0] cosv;
        logic signed [TRIG_W-1:0] sinv;
    } t_pixel;

    class fade_scoreboard;
        logic [COEF_W-1:0]  shape_x, shape_y, fade_x, fade_y;
        logic [SCALE_W-1:0] iscl_x, iscl_y;
        logic [FADE_W-1:0]  pending_fades[$];
        int                 errors;

        function new();
            shape_x = 24'd65536; shape_y = 24'd65536;
            fade_x  = 24'd65536; fade_y  = 24'd65536;
            iscl_x  = 20'd65536; iscl_y  = 20'd65536;
            errors  = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_SHAPE_X: shape_x = val[COEF_W-1:0];
                REG_SHAPE_Y: shape_y = val[COEF_W-1:0];
                REG_FADE_X:  fade_x  = val[COEF_W-1:0];
                REG_FADE_Y:  fade_y  = val[COEF_W-1:0];
                REG_ISCL_X:  iscl_x  = val[SCALE_W-1:0];
                REG_ISCL_Y:  iscl_y  = val[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // >>> on signed longint is an arithmetic shift, i.e. floor division
        function longint unsigned weighted_sq(longint r, logic [COEF_W-1:0] coef);
            longint t;
            longint unsigned a;
            t = (r * longint'(coef)) >>> 16;
            a = (t < 0) ? longint'(-t) : t;
            if (a >= 65536) return 64'h1_0000_0000;
            return a * a;
        endfunction

        function longint unsigned ellipse_norm(longint xr, longint yr,
                                               logic [COEF_W-1:0] kx, logic [COEF_W-1:0] ky);
            longint unsigned s;
            s = weighted_sq(xr, kx) + weighted_sq(yr, ky);
            return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
        endfunction

        function logic [FADE_W-1:0] fade_of(t_pixel p);
            longint col, dx, dy, xs, ys, xr, yr;
            longint unsigned n, f, q;
            col = (p.column >= ROW_MAX) ? ROW_MAX - 1 : p.column;
            dx = col * 256 - longint'(p.cx);
            dy = longint'(p.row_pos) - longint'(p.cy);
            xs = (dx * longint'(iscl_x)) >>> 16;
            ys = (dy * longint'(iscl_y)) >>> 16;
            xr = (xs * longint'(p.cosv) - ys * longint'(p.sinv)) >>> 15;
            yr = (xs * longint'(p.sinv) + ys * longint'(p.cosv)) >>> 15;
            n = ellipse_norm(xr, yr, shape_x, shape_y);
            f = ellipse_norm(xr, yr, fade_x, fade_y);
            if (f < 65536) return '0;
            if (f == n) return FADE_ONE;
            if (f < n) return '0;
            q = (n * (f - 65536)) / (f - n);
            return (q > 65536) ? FADE_ONE : q[FADE_W-1:0];
        endfunction

        function void note_pixel(t_pixel p);
            pending_fades.push_back(fade_of(p));
        endfunction

        function void check_fade(logic [FADE_W-1:0] got);
            logic [FADE_W-1:0] want;
            if (pending_fades.size() == 0) begin
                $display("%0t: unexpected fade, expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending_fades.pop_front();
            if (got !== want) begin
                $display("%0t: fade mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     start = 1'b0;
    logic                     busy;
    logic [COL_W-1:0]         i_column = '0;
    logic signed [POS_W-1:0]  i_row_position = '0;
    logic signed [POS_W-1:0]  i_centre_x = '0;
    logic signed [POS_W-1:0]  i_centre_y = '0;
    logic signed [TRIG_W-1:0] i_cos_angle = '0;
    logic signed [TRIG_W-1:0] i_sin_angle = '0;
    logic                     o_done;
    logic [FADE_W-1:0]        o_fade_value;

    fade_scoreboard sb = new();
    bit                quiet_tail;

    elliptic_fade_mask_pixel_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_fade(o_fade_value);
    end

    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx)); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_fades.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    // Drive one beat; an optional idle burst follows
    task automatic send_pixel(t_pixel p);
        start <= 1'b1;
        i_column <= p.column; i_row_position <= p.row_pos;
        i_centre_x <= p.cx; i_centre_y <= p.cy;
        i_cos_angle <= p.cosv; i_sin_angle <= p.sinv;
        do @(posedge i_clk); while (busy);
        sb.note_pixel(p);
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    function automatic t_pixel rand_pixel(int spread);
        t_pixel p;
        int unsigned col;
        col = $urandom_range(0, ROW_MAX - 1);
        p.column = col[COL_W-1:0];
        p.cx = POS_W'(col * 256 + $signed($urandom_range(0, 2 * spread)) - spread);
        p.cy = POS_W'($urandom);
        p.row_pos = p.cy + POS_W'($signed($urandom_range(0, 2 * spread)) - spread);
        p.cosv = TRIG_W'($urandom);
        p.sinv = TRIG_W'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            p.row_pos = POS_W'($urandom); p.cx = POS_W'($urandom);
        end
        return p;
    endfunction

    // Random beats follow straight after, so start is left to them
    task automatic directed();
        t_pixel p;
        logic signed [POS_W-1:0] pe[4];
        logic signed [TRIG_W-1:0] te[3];
        pe = '{22'sh1FFFFF, -22'sh200000, 22'sd0, 22'sd512};
        te = '{16'sh7FFF, -16'sh8000, 16'sd0};
        for (int k = 0; k < 24; k++) begin
            p.column  = (k % 3 == 0) ? 12'hFFF : COL_W'(k * 3);
            p.row_pos = pe[k % 4];
            p.cx      = pe[(k / 4) % 4];
            p.cy      = pe[(k + 1) % 4];
            p.cosv    = te[k % 3];
            p.sinv    = te[(k / 3) % 3];
            send_pixel(p);
        end
    endtask

    task automatic random_phase(int count, int spread);
        for (int k = 0; k < count; k++) send_pixel(rand_pixel(spread));
        start <= 1'b0;
    endtask

    initial begin
        quiet_tail = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed();
        random_phase(150, 4096);
        // Pause until every expected fade is back
        drain();
        write_reg(REG_SHAPE_X, 32'd98304); write_reg(REG_SHAPE_Y, 32'd131072);
        write_reg(REG_FADE_X, 32'd49152);  write_reg(REG_FADE_Y, 32'd65536);
        write_reg(REG_ISCL_X, 32'd32768);  write_reg(REG_ISCL_Y, 32'd262144);
        random_phase(200, 2048);
        drain();
        write_reg(REG_SHAPE_X, 32'hFFFFFF); write_reg(REG_SHAPE_Y, 32'h0);
        write_reg(REG_FADE_X, 32'hFFFFFF);  write_reg(REG_FADE_Y, 32'hFFFFFF);
        write_reg(REG_ISCL_X, 32'hFFFFF);   write_reg(REG_ISCL_Y, 32'h0);
        random_phase(120, 256);
        drain();
        write_reg(REG_SHAPE_X, 32'd0);     write_reg(REG_SHAPE_Y, 32'd0);
        write_reg(REG_FADE_X, 32'd0);      write_reg(REG_FADE_Y, 32'd0);
        write_reg(REG_ISCL_X, 32'd0);      write_reg(REG_ISCL_Y, 32'd0);
        random_phase(30, 4096);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_SHAPE_X, $urandom_range(0, 24'hFFFFFF));
            write_reg(REG_SHAPE_Y, $urandom_range(0, 24'hFFFFFF));
            write_reg(REG_FADE_X, $urandom_range(0, 24'hFFFFFF));
            write_reg(REG_FADE_Y, $urandom_range(0, 24'hFFFFFF));
            write_reg(REG_ISCL_X, $urandom_range(0, 20'hFFFFF));
            write_reg(REG_ISCL_Y, $urandom_range(0, 20'hFFFFF));
            if (ph == 2) quiet_tail = 1;
            random_phase(110, 1 << $urandom_range(6, 14));
            drain();
        end
        if (sb.errors == 0 && sb.pending_fades.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end
endmodule

[files.f]
rtl/core/efm_pkg.sv
rtl/core/efm_xform.sv
rtl/core/efm_norm.sv
rtl/core/efm_div.sv
rtl/core/elliptic_fade_mask_pixel_unit.sv
dv/elliptic_fade_mask_pixel_unit_test.sv
